@@ design/word_pair_rle_decoder_defines.svh @@
// Assertion macros shared by the decoder RTL
`ifndef WORD_PAIR_RLE_DECODER_DEFINES_SVH
`define WORD_PAIR_RLE_DECODER_DEFINES_SVH

// Checked on every rising edge, quiet while reset is asserted
`define WPR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define WPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/wpr_pkg.sv @@
package wpr_pkg;

	// decoded event queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned ROW_W      = 17;
	localparam int unsigned IMAGE_W    = 32;
	localparam int unsigned TOTAL_W    = 33;
	localparam int unsigned ROWCNT_W   = 18;

	// configuration register indexes
	localparam logic CFG_ROW_BYTES   = 1'b0;
	localparam logic CFG_IMAGE_BYTES = 1'b1;

	// input kinds
	localparam logic KIND_DATA = 1'b0;

	typedef enum logic [2:0] {
		ST_RUN      = 3'd0,
		ST_DONE     = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_TRUNC    = 3'd4
	} status_t;

	// record-boundary check with a data byte, boundary check on end of input,
	// end of input mid-record, and a complete record
	typedef enum logic [1:0] {
		EV_CHECK     = 2'd0,
		EV_CHECK_END = 2'd1,
		EV_TRUNC     = 2'd2,
		EV_RECORD    = 2'd3
	} ev_kind_t;

	typedef enum logic [1:0] {
		PH_COUNT_LO = 2'd0,
		PH_COUNT_HI = 2'd1,
		PH_FIRST    = 2'd2,
		PH_SECOND   = 2'd3
	} phase_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [15:0] count;
		logic [7:0]  first;
		logic [7:0]  second;
	} ev_t;

endpackage

@@ design/word_pair_rle_decoder.sv @@
// Run-length decoder for 4-byte records (16-bit little-endian count, then a
// byte pair). Compressed bytes enter on the input channel (in_valid/in_stall,
// kind 1 marks end of input); run descriptors and status results leave on the
// output channel (out_valid/out_stall), one per transfer, last set on the
// status that ends the stream. row_bytes and image_bytes are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle, as the block does not enforce it. One input byte per cycle while
// in_stall is low. The front assembles records and queues check/record
// events in a 4-entry queue; the back executes one event per cycle while
// the output register can take a result, with a saturating add and compare
// on the byte counters. A result passes through the event queue and then the
// output register; a run that also ends the stream is followed by its status.
// in_stall rises only when the event queue is full, which happens only while
// the receiver holds out_stall; results are held in the output register.
// Reset clears counters, record position, queue and output; the config
// registers reset to zero. After a status result all input is taken and
// dropped until the next reset.
`include "word_pair_rle_decoder_defines.svh"

module word_pair_rle_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [wpr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [7:0]                        data_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        pair_first,
	output logic [7:0]                        pair_second,
	output logic [15:0]                       repeat_count,
	output logic [2:0]                        status,
	output logic                              last
);

	logic [wpr_pkg::ROW_W-1:0]    row_bytes_q;
	logic [wpr_pkg::IMAGE_W-1:0]  image_bytes_q;

	logic                         in_xfer;
	logic                         q_push;
	wpr_pkg::ev_t                 q_push_ev;
	logic                         q_pop;
	wpr_pkg::ev_t                 q_head;
	logic                         q_not_empty;
	logic                         q_full;
	logic [wpr_pkg::QCNT_W-1:0]   q_count;
	logic                         q_has_room;
	logic                         out_xfer;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q   <= '0;
			image_bytes_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wpr_pkg::CFG_ROW_BYTES:   row_bytes_q   <= cfg_data[wpr_pkg::ROW_W-1:0];
				wpr_pkg::CFG_IMAGE_BYTES: image_bytes_q <= cfg_data[wpr_pkg::IMAGE_W-1:0];
				default:                  ;
			endcase
		end
	end

	assign in_stall = q_full;
	assign in_xfer  = in_valid && !in_stall;

	wpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_xfer),
		.kind      (kind),
		.data_byte (data_byte),
		.push      (q_push),
		.ev        (q_push_ev)
	);

	wpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_ev   (q_push_ev),
		.pop       (q_pop),
		.head_ev   (q_head),
		.not_empty (q_not_empty),
		.full      (q_full),
		.count     (q_count)
	);

	wpr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_bytes    (row_bytes_q),
		.image_bytes  (image_bytes_q),
		.ev           (q_head),
		.ev_valid     (q_not_empty),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pair_first   (pair_first),
		.pair_second  (pair_second),
		.repeat_count (repeat_count),
		.status       (status),
		.last         (last)
	);

	assign q_has_room = (q_count < wpr_pkg::QCNT_W'(wpr_pkg::QDEPTH));
	assign out_xfer   = out_valid && !out_stall;

	// queue never pushed past its depth
	`WPR_ASSERT(a_no_overflow, clk, arst_n, q_push |-> q_has_room, "event queue overflow")
	// queue never popped empty
	`WPR_ASSERT(a_no_underflow, clk, arst_n, q_pop |-> q_not_empty, "event queue underflow")
	// nothing follows the final result
	`WPR_ASSERT(a_last_ends, clk, arst_n, (out_xfer && last) |=> !out_valid, "result after last")
	// no result while reset is held
	`WPR_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid, "output valid in reset")

endmodule

@@ design/wpr_front.sv @@
module wpr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          kind,
	input  logic [7:0]    data_byte,
	output logic          push,
	output wpr_pkg::ev_t  ev
);

	wpr_pkg::phase_t phase_q;
	logic [7:0]      count_lo_q;
	logic [7:0]      count_hi_q;
	logic [7:0]      first_q;

	// byte position within the 4-byte record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wpr_pkg::PH_COUNT_LO;
		end else if (accept && kind == wpr_pkg::KIND_DATA) begin
			case (phase_q)
				wpr_pkg::PH_COUNT_LO: phase_q <= wpr_pkg::PH_COUNT_HI;
				wpr_pkg::PH_COUNT_HI: phase_q <= wpr_pkg::PH_FIRST;
				wpr_pkg::PH_FIRST:    phase_q <= wpr_pkg::PH_SECOND;
				default:              phase_q <= wpr_pkg::PH_COUNT_LO;
			endcase
		end
	end

	// record assembly registers
	always_ff @(posedge clk) begin
		if (accept && kind == wpr_pkg::KIND_DATA) begin
			case (phase_q)
				wpr_pkg::PH_COUNT_LO: count_lo_q <= data_byte;
				wpr_pkg::PH_COUNT_HI: count_hi_q <= data_byte;
				wpr_pkg::PH_FIRST:    first_q    <= data_byte;
				default:              ;
			endcase
		end
	end

	// classify the transfer into a queue event
	always_comb begin
		push      = 1'b0;
		ev.kind   = wpr_pkg::EV_CHECK;
		ev.count  = {count_hi_q, count_lo_q};
		ev.first  = first_q;
		ev.second = data_byte;
		if (accept) begin
			if (kind != wpr_pkg::KIND_DATA) begin
				push    = 1'b1;
				ev.kind = (phase_q == wpr_pkg::PH_COUNT_LO) ? wpr_pkg::EV_CHECK_END
					: wpr_pkg::EV_TRUNC;
			end else if (phase_q == wpr_pkg::PH_COUNT_LO) begin
				push    = 1'b1;
				ev.kind = wpr_pkg::EV_CHECK;
			end else if (phase_q == wpr_pkg::PH_SECOND) begin
				push    = 1'b1;
				ev.kind = wpr_pkg::EV_RECORD;
			end
		end
	end

endmodule

@@ design/wpr_queue.sv @@
module wpr_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  wpr_pkg::ev_t                push_ev,
	input  logic                        pop,
	output wpr_pkg::ev_t                head_ev,
	output logic                        not_empty,
	output logic                        full,
	output logic [wpr_pkg::QCNT_W-1:0]  count
);

	wpr_pkg::ev_t                entry_q [wpr_pkg::QDEPTH];
	logic [wpr_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [wpr_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [wpr_pkg::QCNT_W-1:0]  count_q;

	assign count     = count_q;
	assign full      = (count_q == wpr_pkg::QCNT_W'(wpr_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head_ev   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_ev;
		end
	end

endmodule

@@ design/wpr_back.sv @@
module wpr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [wpr_pkg::ROW_W-1:0]     row_bytes,
	input  logic [wpr_pkg::IMAGE_W-1:0]   image_bytes,
	input  wpr_pkg::ev_t                  ev,
	input  logic                          ev_valid,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    pair_first,
	output logic [7:0]                    pair_second,
	output logic [15:0]                   repeat_count,
	output logic [2:0]                    status,
	output logic                          last
);

	localparam int unsigned TSUM_W = wpr_pkg::TOTAL_W + 1;
	localparam int unsigned RSUM_W = wpr_pkg::ROWCNT_W + 1;

	logic [wpr_pkg::TOTAL_W-1:0]  total_q;
	logic [wpr_pkg::ROWCNT_W-1:0] row_q;
	logic                         stopped_q;
	logic                         pend_q;
	wpr_pkg::status_t             pend_st_q;

	logic                         out_valid_q;
	logic [7:0]                   out_first_q;
	logic [7:0]                   out_second_q;
	logic [15:0]                  out_count_q;
	wpr_pkg::status_t             out_st_q;

	logic                         slot_free;
	logic                         work;
	logic [16:0]                  cnt2;
	logic [TSUM_W-1:0]            tot_sum;
	logic [RSUM_W-1:0]            row_sum;
	logic [wpr_pkg::TOTAL_W-1:0]  tot_add;
	logic [wpr_pkg::ROWCNT_W-1:0] row_add;
	logic [wpr_pkg::TOTAL_W-1:0]  image_ext;
	logic [wpr_pkg::ROWCNT_W-1:0] row_ext;

	logic                         r1_valid;
	wpr_pkg::status_t             r1_st;
	logic                         r2_valid;
	wpr_pkg::status_t             r2_st;
	logic [wpr_pkg::TOTAL_W-1:0]  total_d;
	logic [wpr_pkg::ROWCNT_W-1:0] row_d;
	logic                         stop_d;

	assign slot_free = !out_valid_q || !out_stall;
	// events after a stop are drained and dropped
	assign pop  = ev_valid && (stopped_q || (!pend_q && slot_free));
	assign work = pop && !stopped_q;

	// saturating counter updates for a run
	assign cnt2      = {ev.count, 1'b0};
	assign tot_sum   = {1'b0, total_q} + TSUM_W'(cnt2);
	assign row_sum   = {1'b0, row_q} + RSUM_W'(cnt2);
	assign tot_add   = tot_sum[TSUM_W-1] ? '1 : tot_sum[wpr_pkg::TOTAL_W-1:0];
	assign row_add   = row_sum[RSUM_W-1] ? '1 : row_sum[wpr_pkg::ROWCNT_W-1:0];
	assign image_ext = wpr_pkg::TOTAL_W'(image_bytes);
	assign row_ext   = wpr_pkg::ROWCNT_W'(row_bytes);

	// event execution: up to two results
	always_comb begin
		r1_valid = 1'b0;
		r1_st    = wpr_pkg::ST_RUN;
		r2_valid = 1'b0;
		r2_st    = wpr_pkg::ST_DONE;
		total_d  = total_q;
		row_d    = row_q;
		stop_d   = 1'b0;
		if (work) begin
			case (ev.kind)
				wpr_pkg::EV_CHECK, wpr_pkg::EV_CHECK_END: begin
					if (total_q >= image_ext) begin
						r1_valid = 1'b1;
						r1_st    = wpr_pkg::ST_DONE;
					end else if (row_q > row_ext) begin
						r1_valid = 1'b1;
						r1_st    = wpr_pkg::ST_OVERFLOW;
					end else if (ev.kind == wpr_pkg::EV_CHECK_END) begin
						r1_valid = 1'b1;
						r1_st    = wpr_pkg::ST_TRUNC;
					end
					stop_d = r1_valid;
				end
				wpr_pkg::EV_TRUNC: begin
					r1_valid = 1'b1;
					r1_st    = wpr_pkg::ST_TRUNC;
					stop_d   = 1'b1;
				end
				default: begin
					if (ev.count == '0) begin
						// end-of-row marker
						if (row_q != row_ext) begin
							r1_valid = 1'b1;
							r1_st    = wpr_pkg::ST_MISMATCH;
							stop_d   = 1'b1;
						end else begin
							row_d = '0;
							if (total_q >= image_ext) begin
								r1_valid = 1'b1;
								r1_st    = wpr_pkg::ST_DONE;
								stop_d   = 1'b1;
							end
						end
					end else begin
						r1_valid = 1'b1;
						r1_st    = wpr_pkg::ST_RUN;
						total_d  = tot_add;
						row_d    = row_add;
						if (tot_add >= image_ext) begin
							r2_valid = 1'b1;
							r2_st    = wpr_pkg::ST_DONE;
						end else if (row_add > row_ext) begin
							r2_valid = 1'b1;
							r2_st    = wpr_pkg::ST_OVERFLOW;
						end
						stop_d = r2_valid;
					end
				end
			endcase
		end
	end

	// counters and stop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			row_q     <= '0;
			stopped_q <= 1'b0;
		end else if (work) begin
			total_q   <= total_d;
			row_q     <= row_d;
			stopped_q <= stop_d;
		end
	end

	// output register; a trailing status waits in the pending slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (slot_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= r1_valid;
				pend_q      <= r1_valid && r2_valid;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (pend_q) begin
				out_first_q  <= '0;
				out_second_q <= '0;
				out_count_q  <= '0;
				out_st_q     <= pend_st_q;
			end else if (r1_valid) begin
				out_first_q  <= (r1_st == wpr_pkg::ST_RUN) ? ev.first : '0;
				out_second_q <= (r1_st == wpr_pkg::ST_RUN) ? ev.second : '0;
				out_count_q  <= (r1_st == wpr_pkg::ST_RUN) ? ev.count : '0;
				out_st_q     <= r1_st;
				pend_st_q    <= r2_st;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pair_first   = out_first_q;
	assign pair_second  = out_second_q;
	assign repeat_count = out_count_q;
	assign status       = out_st_q;
	assign last         = (out_st_q != wpr_pkg::ST_RUN);

endmodule
